/* rtl/core/ikc_pkg.sv */
// Shared constants, codes and types of the image kernel convolution block.
package ikc_pkg;

    localparam int MAX_KERNEL   = 15;
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_ROWS     = 2048;

    localparam int SAMPLE_W   = 8;
    localparam int COEF_W     = 18;
    localparam int COEF_IDX_W = 8;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = COEF_W + SAMPLE_W + 1;
    localparam int FILT_W     = 8;
    localparam int ROW_W      = 11;
    localparam int COL_W      = 13;
    localparam int HEIGHT_W   = 12;
    localparam int NC_W       = 3;
    localparam int KS_W       = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [KS_W-1:0]     RST_KERNEL_SIZE   = 4'd15;
    localparam logic [11:0]         RST_IMAGE_WIDTH   = 12'd2048;
    localparam logic [11:0]         RST_IMAGE_HEIGHT  = 12'd2048;
    localparam logic [NC_W-1:0]     RST_CHANNEL_COUNT = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_SIZE   = 2'd0,
        CFG_IMAGE_WIDTH   = 2'd1,
        CFG_IMAGE_HEIGHT  = 2'd2,
        CFG_CHANNEL_COUNT = 2'd3
    } t_cfg_reg;

    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic            shift;
        logic [NC_W-1:0] nc;
    } t_cell_ctrl;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_side;

    typedef struct packed {
        logic [FILT_W-1:0] filtered;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } t_result;

endpackage

/* rtl/core/ikc_in_if.sv */
// Input channel: coefficient loads and image sample bytes.
interface ikc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic [ikc_pkg::COEF_IDX_W-1:0]       coef_index;
    logic signed [ikc_pkg::COEF_W-1:0]    coef_value;
    logic [ikc_pkg::SAMPLE_W-1:0]         sample;

    modport source (output valid, cmd, coef_index, coef_value, sample, input ready);
    modport sink   (input valid, cmd, coef_index, coef_value, sample, output ready);
endinterface

/* rtl/core/ikc_out_if.sv */
// Output channel: filtered bytes with their position in the frame.
interface ikc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ikc_pkg::FILT_W-1:0]    filtered;
    logic [ikc_pkg::ROW_W-1:0]     out_row;
    logic [ikc_pkg::COL_W-1:0]     out_byte_col;
    logic                          frame_last;

    modport source (output valid, filtered, out_row, out_byte_col, frame_last, input ready);
    modport sink   (input valid, filtered, out_row, out_byte_col, frame_last, output ready);
endinterface

/* rtl/core/ikc_line_bank.sv */
// One line buffer: a row of sample bytes with registered read and write forwarding.
module ikc_line_bank #(
    parameter int DEPTH = ikc_pkg::MAX_WIDTH * ikc_pkg::MAX_CHANNELS
) (
    input  logic                             i_clk,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [ikc_pkg::SAMPLE_W-1:0]     i_wr_data,
    output logic [ikc_pkg::SAMPLE_W-1:0]     o_q
);

    logic [ikc_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [ikc_pkg::SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            // same address written this cycle: take the new byte
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_q <= i_wr_data;
            end else begin
                r_q <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_q = r_q;

endmodule

/* rtl/core/ikc_sum_tree.sv */
// Registered binary adder tree, one register level per pairwise add.
module ikc_sum_tree #(
    parameter int N  = ikc_pkg::MAX_KERNEL,
    parameter int IW = ikc_pkg::PROD_W,
    parameter int OW = ikc_pkg::PROD_W + 4
) (
    input  logic                 i_clk,
    input  logic signed [IW-1:0] i_val [N],
    output logic signed [OW-1:0] o_sum
);

    localparam int LV = (N > 1) ? $clog2(N) : 1;
    localparam int P  = 1 << LV;

    logic signed [OW-1:0] w_node [2*P-1];
    logic signed [OW-1:0] r_node [P-1];

    for (genvar i = 0; i < P; i++) begin : g_leaf
        if (i < N) begin : g_used
            assign w_node[P-1+i] = OW'(i_val[i]);
        end else begin : g_pad
            assign w_node[P-1+i] = '0;
        end
    end

    for (genvar n = 0; n < P-1; n++) begin : g_add
        always_ff @(posedge i_clk) begin
            r_node[n] <= w_node[2*n+1] + w_node[2*n+2];
        end
        assign w_node[n] = r_node[n];
    end

    assign o_sum = w_node[0];

endmodule

/* rtl/core/ikc_cell.sv */
// Window cell: one kernel column of taps, its products and its column sum.
module ikc_cell #(
    parameter int MAX_KERNEL   = ikc_pkg::MAX_KERNEL,
    parameter int MAX_CHANNELS = ikc_pkg::MAX_CHANNELS,
    parameter int CW           = ikc_pkg::PROD_W + 4
) (
    input  logic                                 i_clk,
    input  ikc_pkg::t_cell_ctrl                  i_ctrl,
    input  logic [ikc_pkg::SAMPLE_W-1:0]         i_col  [MAX_KERNEL],
    input  logic signed [ikc_pkg::COEF_W-1:0]    i_coef [MAX_KERNEL],
    output logic [ikc_pkg::SAMPLE_W-1:0]         o_tap  [MAX_KERNEL],
    output logic signed [CW-1:0]                 o_sum
);

    localparam int SW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [ikc_pkg::SAMPLE_W-1:0]        r_dly [MAX_CHANNELS][MAX_KERNEL];
    logic signed [ikc_pkg::PROD_W-1:0]   r_prod [MAX_KERNEL];
    logic [SW-1:0]                       w_sel;

    // advance the column delay one step per accepted sample
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_dly[0] <= i_col;
            for (int i = 1; i < MAX_CHANNELS; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign w_sel = SW'(i_ctrl.nc - ikc_pkg::NC_W'(1));
    assign o_tap = r_dly[w_sel];

    // drop taps with a zero coefficient, so unfilled line storage never reaches the sum
    always_ff @(posedge i_clk) begin
        for (int d = 0; d < MAX_KERNEL; d++) begin
            if (i_coef[d] == '0) begin
                r_prod[d] <= '0;
            end else begin
                r_prod[d] <= i_coef[d] * $signed({1'b0, i_col[d]});
            end
        end
    end

    ikc_sum_tree #(
        .N  (MAX_KERNEL),
        .IW (ikc_pkg::PROD_W),
        .OW (CW)
    ) u_tree (
        .i_clk (i_clk),
        .i_val (r_prod),
        .o_sum (o_sum)
    );

endmodule

/* rtl/core/image_kernel_convolution.sv */
// Top level of the streaming 2-D image convolution (line buffers, window cells, output queue).
//
// Streaming 2-D convolution of a channel-interleaved 8-bit image. Sample bytes and coefficient
// loads share the input channel and are taken at one transfer per clock; ready drops only when
// the output queue plus the results still in the pipe reach its depth (16 with the default
// kernel), i.e. when the consumer stops taking results. A sample whose window lies fully inside
// the frame yields one result, passing through a registered line buffer read, the MAX_KERNEL x
// MAX_KERNEL parallel multipliers, two registered adder trees (column sums inside each cell,
// then across cells) and one rounding stage. Border samples yield no result. MAX_KERNEL-1
// line buffers of MAX_WIDTH*MAX_CHANNELS bytes hold the previous rows; their contents start
// undefined and need no clearing pass, since only rows of the current frame are ever used and
// taps outside the kernel in force carry a zero coefficient and are dropped. Coefficients are
// indexed row*kernel_size+column and are looked up for the kernel size in force. A configuration
// write restarts the frame.
module image_kernel_convolution #(
    parameter int MAX_KERNEL   = ikc_pkg::MAX_KERNEL,
    parameter int MAX_WIDTH    = ikc_pkg::MAX_WIDTH,
    parameter int MAX_CHANNELS = ikc_pkg::MAX_CHANNELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ikc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ikc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ikc_in_if.sink                            i_in,
    ikc_out_if.source                         o_out
);

    localparam int ROW_BYTES  = MAX_WIDTH * MAX_CHANNELS;
    localparam int BCW        = $clog2(ROW_BYTES);
    localparam int RBW        = BCW + 1;
    localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int KLIM       = (MAX_KERNEL - 1) | 1;
    localparam int NBANK      = MAX_KERNEL - 1;
    localparam int NBD        = (NBANK > 0) ? NBANK : 1;
    localparam int LT         = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CW         = ikc_pkg::PROD_W + LT;
    localparam int AW         = CW + LT;
    localparam int QW         = AW - ikc_pkg::FRAC_W;
    localparam int SD         = 3 + 2 * LT;
    localparam int FAW        = $clog2(SD + 4);
    localparam int FDEPTH     = 1 << FAW;
    localparam logic [FAW:0] CREDIT_MAX = (FAW+1)'(FDEPTH);

    // ---------------- configuration registers ----------------
    logic [ikc_pkg::KS_W-1:0]   r_kernel_size;
    logic [11:0]                r_image_width;
    logic [11:0]                r_image_height;
    logic [ikc_pkg::NC_W-1:0]   r_channel_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_size   <= ikc_pkg::RST_KERNEL_SIZE;
            r_image_width   <= ikc_pkg::RST_IMAGE_WIDTH;
            r_image_height  <= ikc_pkg::RST_IMAGE_HEIGHT;
            r_channel_count <= ikc_pkg::RST_CHANNEL_COUNT;
        end else if (i_cfg_we) begin
            unique case (ikc_pkg::t_cfg_reg'(i_cfg_index))
                ikc_pkg::CFG_KERNEL_SIZE:   r_kernel_size   <= i_cfg_data[3:0];
                ikc_pkg::CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data;
                ikc_pkg::CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data;
                ikc_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // ---------------- effective geometry ----------------
    logic [ikc_pkg::KS_W-1:0]      w_k1, w_k, w_km1, w_half;
    logic [ikc_pkg::NC_W-1:0]      w_nc;
    logic [RBW-1:0]                w_width, w_rowbytes, w_left_off, w_half_off;
    logic [ikc_pkg::HEIGHT_W-1:0]  w_height;

    always_comb begin
        // even sizes act as the next odd size, capped at the largest odd size that fits
        w_k1 = r_kernel_size | ikc_pkg::KS_W'(1);
        w_k  = (int'(w_k1) > KLIM) ? ikc_pkg::KS_W'(KLIM) : w_k1;
        w_km1  = w_k - ikc_pkg::KS_W'(1);
        w_half = w_k >> 1;

        if (r_channel_count == '0) begin
            w_nc = ikc_pkg::NC_W'(1);
        end else if (int'(r_channel_count) > MAX_CHANNELS) begin
            w_nc = ikc_pkg::NC_W'(MAX_CHANNELS);
        end else begin
            w_nc = r_channel_count;
        end

        if (r_image_width == '0) begin
            w_width = RBW'(1);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_width = RBW'(MAX_WIDTH);
        end else begin
            w_width = RBW'(r_image_width);
        end

        if (r_image_height == '0) begin
            w_height = ikc_pkg::HEIGHT_W'(1);
        end else if (int'(r_image_height) > ikc_pkg::MAX_ROWS) begin
            w_height = ikc_pkg::HEIGHT_W'(ikc_pkg::MAX_ROWS);
        end else begin
            w_height = r_image_height;
        end

        w_rowbytes = w_width * RBW'(w_nc);
        w_left_off = RBW'(w_nc) * RBW'(w_km1);
        w_half_off = RBW'(w_nc) * RBW'(w_half);
    end

    // ---------------- position counters ----------------
    logic [ikc_pkg::ROW_W-1:0]     r_row;
    logic [BCW-1:0]                r_byte;
    logic [ikc_pkg::ROW_W-1:0]     w_r;
    logic [BCW-1:0]                w_c;
    logic [RBW-1:0]                w_c_ext, w_c_next;
    logic [ikc_pkg::HEIGHT_W-1:0]  w_r_next;
    logic                          w_interior;
    logic                          w_xfer, w_smp, w_coef_we;
    ikc_pkg::t_side                w_side;

    assign w_xfer    = i_in.valid & i_in.ready;
    assign w_smp     = w_xfer & (i_in.cmd == ikc_pkg::CMD_SAMPLE);
    assign w_coef_we = w_xfer & (i_in.cmd == ikc_pkg::CMD_COEF);

    always_comb begin
        w_c      = (RBW'(r_byte) >= w_rowbytes) ? '0 : r_byte;
        w_r      = ({1'b0, r_row} >= w_height) ? '0 : r_row;
        w_c_ext  = RBW'(w_c);
        w_c_next = w_c_ext + RBW'(1);
        w_r_next = {1'b0, w_r} + ikc_pkg::HEIGHT_W'(1);
        w_interior = (w_r >= ikc_pkg::ROW_W'(w_km1)) && (w_c_ext >= w_left_off);

        w_side.valid = w_smp & w_interior;
        w_side.row   = w_r - ikc_pkg::ROW_W'(w_half);
        w_side.col   = ikc_pkg::COL_W'(w_c_ext - w_half_off);
        w_side.last  = (w_r == ikc_pkg::ROW_W'(w_height - ikc_pkg::HEIGHT_W'(1)))
                       && (w_c_next == w_rowbytes);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_byte <= '0;
        end else if (i_cfg_we) begin
            // restart the frame
            r_row  <= '0;
            r_byte <= '0;
        end else if (w_smp) begin
            if (w_c_next >= w_rowbytes) begin
                r_byte <= '0;
                r_row  <= (w_r_next >= w_height) ? '0 : w_r_next[ikc_pkg::ROW_W-1:0];
            end else begin
                r_byte <= w_c_next[BCW-1:0];
            end
        end
    end

    // ---------------- coefficient store ----------------
    logic signed [ikc_pkg::COEF_W-1:0] r_coef [COEF_DEPTH];

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < COEF_DEPTH; e++) begin
            if (w_coef_we && (int'(i_in.coef_index) == e)) begin
                r_coef[e] <= i_in.coef_value;
            end
        end
    end

    // Per tap, pick the coefficient that belongs to it under the kernel size in force.
    // Cell m holds the tap m columns back, row age d counts rows up from the newest.
    logic signed [ikc_pkg::COEF_W-1:0] n_cgrid [MAX_KERNEL][MAX_KERNEL];
    logic signed [ikc_pkg::COEF_W-1:0] r_cgrid [MAX_KERNEL][MAX_KERNEL];

    always_comb begin
        for (int m = 0; m < MAX_KERNEL; m++) begin
            for (int d = 0; d < MAX_KERNEL; d++) begin
                n_cgrid[m][d] = '0;
                for (int kk = 1; kk <= KLIM; kk += 2) begin
                    if ((int'(w_k) == kk) && (m < kk) && (d < kk)) begin
                        n_cgrid[m][d] = r_coef[(kk-1-d)*kk + (kk-1-m)];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cgrid <= n_cgrid;
    end

    // ---------------- first stage after the transfer ----------------
    logic                           r_s1_go;
    logic [ikc_pkg::SAMPLE_W-1:0]   r_s1_sample;
    logic [BCW-1:0]                 r_s1_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_go <= 1'b0;
        end else begin
            r_s1_go <= w_smp;
        end
        r_s1_sample <= i_in.sample;
        r_s1_col    <= w_c;
    end

    // ---------------- line buffers ----------------
    // Bank j holds the row j+1 above the current one; each write pushes a byte one bank up.
    logic [ikc_pkg::SAMPLE_W-1:0] w_bank_q [NBD];
    logic [ikc_pkg::SAMPLE_W-1:0] w_col0   [MAX_KERNEL];

    for (genvar j = 0; j < NBANK; j++) begin : g_bank
        logic [ikc_pkg::SAMPLE_W-1:0] w_wr_data;
        if (j == 0) begin : g_head
            assign w_wr_data = r_s1_sample;
        end else begin : g_next
            assign w_wr_data = w_bank_q[j-1];
        end
        ikc_line_bank #(
            .DEPTH (ROW_BYTES)
        ) u_bank (
            .i_clk     (i_clk),
            .i_rd_en   (w_smp),
            .i_rd_addr (w_c),
            .i_wr_en   (r_s1_go),
            .i_wr_addr (r_s1_col),
            .i_wr_data (w_wr_data),
            .o_q       (w_bank_q[j])
        );
    end

    if (NBANK == 0) begin : g_no_bank
        assign w_bank_q[0] = '0;
    end

    for (genvar d = 0; d < MAX_KERNEL; d++) begin : g_col
        if (d == 0) begin : g_new
            assign w_col0[d] = r_s1_sample;
        end else begin : g_old
            assign w_col0[d] = w_bank_q[d-1];
        end
    end

    // ---------------- window cells ----------------
    ikc_pkg::t_cell_ctrl           w_ctrl;
    logic [ikc_pkg::SAMPLE_W-1:0]  w_tap  [MAX_KERNEL][MAX_KERNEL];
    logic signed [CW-1:0]          w_csum [MAX_KERNEL];
    logic signed [AW-1:0]          w_acc;

    assign w_ctrl.shift = r_s1_go;
    assign w_ctrl.nc    = w_nc;

    for (genvar m = 0; m < MAX_KERNEL; m++) begin : g_cell
        if (m == 0) begin : g_first
            ikc_cell #(
                .MAX_KERNEL   (MAX_KERNEL),
                .MAX_CHANNELS (MAX_CHANNELS),
                .CW           (CW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl),
                .i_col  (w_col0),
                .i_coef (r_cgrid[m]),
                .o_tap  (w_tap[m]),
                .o_sum  (w_csum[m])
            );
        end else begin : g_rest
            ikc_cell #(
                .MAX_KERNEL   (MAX_KERNEL),
                .MAX_CHANNELS (MAX_CHANNELS),
                .CW           (CW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl),
                .i_col  (w_tap[m-1]),
                .i_coef (r_cgrid[m]),
                .o_tap  (w_tap[m]),
                .o_sum  (w_csum[m])
            );
        end
    end

    ikc_sum_tree #(
        .N  (MAX_KERNEL),
        .IW (CW),
        .OW (AW)
    ) u_total (
        .i_clk (i_clk),
        .i_val (w_csum),
        .o_sum (w_acc)
    );

    // ---------------- round half to even, clamp to a byte ----------------
    logic [QW-1:0]               w_q;
    logic [ikc_pkg::FRAC_W-1:0]  w_rem;
    logic                        w_up;
    logic [QW:0]                 w_q1;
    logic [ikc_pkg::FILT_W-1:0]  r_filt;

    always_comb begin
        w_q   = w_acc[AW-1:ikc_pkg::FRAC_W];
        w_rem = w_acc[ikc_pkg::FRAC_W-1:0];
        w_up  = (w_rem > {1'b1, {(ikc_pkg::FRAC_W-1){1'b0}}})
                || ((w_rem == {1'b1, {(ikc_pkg::FRAC_W-1){1'b0}}}) && w_q[0]);
        w_q1  = {1'b0, w_q} + (QW+1)'(w_up);
    end

    always_ff @(posedge i_clk) begin
        if (w_acc[AW-1]) begin
            r_filt <= '0;
        end else if (w_q1 > (QW+1)'(255)) begin
            r_filt <= '1;
        end else begin
            r_filt <= w_q1[ikc_pkg::FILT_W-1:0];
        end
    end

    // ---------------- side information, aligned with the rounded sum ----------------
    ikc_pkg::t_side r_side [SD];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SD; s++) begin
                r_side[s].valid <= 1'b0;
            end
        end else begin
            r_side[0].valid <= w_side.valid;
            for (int s = 1; s < SD; s++) begin
                r_side[s].valid <= r_side[s-1].valid;
            end
        end
        r_side[0].row  <= w_side.row;
        r_side[0].col  <= w_side.col;
        r_side[0].last <= w_side.last;
        for (int s = 1; s < SD; s++) begin
            r_side[s].row  <= r_side[s-1].row;
            r_side[s].col  <= r_side[s-1].col;
            r_side[s].last <= r_side[s-1].last;
        end
    end

    // ---------------- output queue and credit ----------------
    // Credit counts results promised at input transfer and not yet delivered, so the queue
    // can never overflow while the pipe runs freely.
    ikc_pkg::t_result  r_fifo [FDEPTH];
    logic [FAW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [FAW:0]      r_fcount, r_credit;
    logic              w_push, w_pop;
    ikc_pkg::t_result  w_push_data, w_head;

    assign w_push = r_side[SD-1].valid;
    assign w_pop  = o_out.valid & o_out.ready;

    assign w_push_data.filtered = r_filt;
    assign w_push_data.row      = r_side[SD-1].row;
    assign w_push_data.col      = r_side[SD-1].col;
    assign w_push_data.last     = r_side[SD-1].last;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcount <= '0;
            r_credit <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + FAW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FAW'(1);
            end
            r_fcount <= r_fcount + (FAW+1)'(w_push) - (FAW+1)'(w_pop);
            r_credit <= r_credit + (FAW+1)'(w_side.valid) - (FAW+1)'(w_pop);
        end
    end

    assign w_head = r_fifo[r_rd_ptr];

    assign i_in.ready         = (r_credit != CREDIT_MAX);
    assign o_out.valid        = (r_fcount != '0);
    assign o_out.filtered     = w_head.filtered;
    assign o_out.out_row      = w_head.row;
    assign o_out.out_byte_col = w_head.col;
    assign o_out.frame_last   = w_head.last;

`ifndef NO_ASSERTIONS
    // queue never receives a result while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_fcount != CREDIT_MAX))
        else $error("output queue overflow");

    // every queued result was promised at input transfer
    a_credit_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit >= r_fcount)
        else $error("credit below queue fill");

    // a result waiting at the output keeps the credit above zero until delivered
    a_credit_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_credit == '0) |-> !o_out.valid)
        else $error("result without credit");
`endif

endmodule

/* bench/tb_image_kernel_convolution.sv */
// Self-checking testbench for the streaming image kernel convolution block.
module tb_image_kernel_convolution;

    localparam int LIMIT_CYCLES = 600000;
    localparam int MAX_KERNEL   = ikc_pkg::MAX_KERNEL;
    localparam int MAX_WIDTH    = ikc_pkg::MAX_WIDTH;
    localparam int MAX_CHANNELS = ikc_pkg::MAX_CHANNELS;
    localparam int MAX_ROWS     = ikc_pkg::MAX_ROWS;
    localparam int COEF_W       = ikc_pkg::COEF_W;
    localparam int COEF_IDX_W   = ikc_pkg::COEF_IDX_W;
    localparam int CFG_DATA_W   = ikc_pkg::CFG_DATA_W;
    localparam int KLIM         = (MAX_KERNEL - 1) | 1;
    localparam int COEF_DEPTH   = MAX_KERNEL * MAX_KERNEL;
    localparam int ROW_BYTES    = MAX_WIDTH * MAX_CHANNELS;
    // Settle time before a register write: pipe depth plus margin
    localparam int SETTLE       = 40;

    // Convolution predictor and the queue of filtered bytes still owed by the block
    class conv_scoreboard;
        logic signed [COEF_W-1:0] coefs[COEF_DEPTH];
        logic [7:0]  lines[MAX_KERNEL][ROW_BYTES];
        int unsigned ksize, width, height, nchan;
        int unsigned row, col;
        ikc_pkg::t_result owed[$];
        int          mismatches;
        int          results_seen;
        int          last_flags;

        function new();
            ksize = ikc_pkg::RST_KERNEL_SIZE;
            width = ikc_pkg::RST_IMAGE_WIDTH;
            height = ikc_pkg::RST_IMAGE_HEIGHT;
            nchan = ikc_pkg::RST_CHANNEL_COUNT;
            row = 0;
            col = 0;
            mismatches = 0;
            results_seen = 0;
            last_flags = 0;
        endfunction

        function void configure(ikc_pkg::t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                ikc_pkg::CFG_KERNEL_SIZE:   ksize = data[ikc_pkg::KS_W-1:0];
                ikc_pkg::CFG_IMAGE_WIDTH:   width = data[11:0];
                ikc_pkg::CFG_IMAGE_HEIGHT:  height = data[11:0];
                ikc_pkg::CFG_CHANNEL_COUNT: nchan = data[ikc_pkg::NC_W-1:0];
                default: ;
            endcase
            row = 0;
            col = 0;
        endfunction

        // Round to nearest, ties to even, then clamp to a byte
        function logic [7:0] round_byte(longint acc);
            longint q;
            longint rem;
            if (acc < 0) return 8'd0;
            q = acc >>> ikc_pkg::FRAC_W;
            rem = acc & 64'hFFFF;
            if (rem > 64'h8000 || (rem == 64'h8000 && q[0])) q++;
            return (q > 255) ? 8'd255 : q[7:0];
        endfunction

        function void note_transfer(logic cmd, logic [COEF_IDX_W-1:0] idx,
                                    logic signed [COEF_W-1:0] val, logic [7:0] smp);
            int unsigned k, nc, w, h, rb, r, c, top, left;
            longint acc;
            ikc_pkg::t_result res;
            if (cmd == ikc_pkg::CMD_COEF) begin
                if (idx < COEF_DEPTH) coefs[idx] = val;
                return;
            end
            k = ksize | 1;
            if (k > KLIM) k = KLIM;
            nc = (nchan < 1) ? 1 : (nchan > MAX_CHANNELS) ? MAX_CHANNELS : nchan;
            w = (width < 1) ? 1 : (width > MAX_WIDTH) ? MAX_WIDTH : width;
            h = (height < 1) ? 1 : (height > MAX_ROWS) ? MAX_ROWS : height;
            rb = w * nc;
            if (col >= rb) col = 0;
            if (row >= h) row = 0;
            r = row;
            c = col;
            lines[r % MAX_KERNEL][c] = smp;
            if (r >= k - 1 && c >= nc * (k - 1)) begin
                acc = 0;
                top = r - (k - 1);
                left = c - nc * (k - 1);
                for (int a = 0; a < k; a++)
                    for (int b = 0; b < k; b++)
                        acc += longint'(coefs[a * k + b]) *
                               longint'(lines[(top + a) % MAX_KERNEL][left + nc * b]);
                res.filtered = round_byte(acc);
                res.row = ikc_pkg::ROW_W'(r - k / 2);
                res.col = ikc_pkg::COL_W'(c - nc * (k / 2));
                res.last = (r == h - 1 && c == rb - 1);
                owed = {owed, res};
            end
            if (c + 1 >= rb) begin
                col = 0;
                row = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col = c + 1;
            end
        endfunction

        function void check_result(ikc_pkg::t_result got);
            ikc_pkg::t_result want;
            results_seen++;
            if (got.last) last_flags++;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result byte=%0d row=%0d col=%0d last=%0b",
                             got.filtered, got.row, got.col, got.last);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d expected byte=%0d row=%0d col=%0d last=%0b,",
                              " got byte=%0d row=%0d col=%0d last=%0b"},
                             results_seen, want.filtered, want.row, want.col, want.last,
                             got.filtered, got.row, got.col, got.last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [ikc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]          i_cfg_data = '0;

    ikc_in_if  in_ch();
    ikc_out_if out_ch();

    conv_scoreboard sb;
    int  cycles = 0;
    int  items_sent = 0;
    int  phases_run = 0;
    bit  steady = 1'b0;   // suppress idling on both sides

    image_kernel_convolution dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Consumer: stall at random unless a steady stretch is running
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= steady || ($urandom_range(99) >= 31);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sample at the falling edge: the values here are the ones the next rising edge takes
    always @(negedge i_clk) begin
        ikc_pkg::t_result got;
        if (i_rst_n) begin
            if (i_cfg_we) sb.configure(ikc_pkg::t_cfg_reg'(i_cfg_index), i_cfg_data);
            if (in_ch.valid && in_ch.ready)
                sb.note_transfer(in_ch.cmd, in_ch.coef_index, in_ch.coef_value, in_ch.sample);
            if (out_ch.valid && out_ch.ready) begin
                got.filtered = out_ch.filtered;
                got.row = out_ch.out_row;
                got.col = out_ch.out_byte_col;
                got.last = out_ch.frame_last;
                sb.check_result(got);
            end
        end
    end

    // Drive one item and hold it until the transfer happens
    task automatic push_item(logic cmd, logic [COEF_IDX_W-1:0] idx,
                             logic signed [COEF_W-1:0] val, logic [7:0] smp);
        bit took;
        while (!steady && $urandom_range(99) < 31) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cmd;
        in_ch.coef_index <= idx;
        in_ch.coef_value <= val;
        in_ch.sample <= smp;
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
        items_sent++;
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold off until every owed result has come, then let the pipe settle
    task automatic drain();
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(ikc_pkg::t_cfg_reg idx, int unsigned data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Blur-like small positive taps, or wide signed taps that push into both clamps
    function automatic logic signed [COEF_W-1:0] pick_coef(bit wide, int unsigned k);
        if (wide) return COEF_W'($urandom);
        return COEF_W'($urandom_range(0, (2 * 65536) / (k * k)));
    endfunction

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // One configuration: write every register, load the taps in use, stream bytes
    task automatic run_phase(int unsigned ks, int unsigned w, int unsigned h, int unsigned nc,
                             int unsigned nbytes, bit wide, bit pause_midway);
        int unsigned k;
        k = ks | 1;
        if (k > KLIM) k = KLIM;
        drain();
        write_reg(ikc_pkg::CFG_KERNEL_SIZE, ks);
        write_reg(ikc_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(ikc_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(ikc_pkg::CFG_CHANNEL_COUNT, nc);
        for (int i = 0; i < k * k; i++)
            push_item(ikc_pkg::CMD_COEF, COEF_IDX_W'(i), pick_coef(wide, k), 8'($urandom));
        for (int n = 0; n < nbytes; n++) begin
            // Retune a tap now and then while the stream runs
            if ($urandom_range(99) < 3)
                push_item(ikc_pkg::CMD_COEF, COEF_IDX_W'($urandom_range(0, k * k - 1)),
                          pick_coef(wide, k), 8'($urandom));
            if (pause_midway && n == nbytes / 2) begin
                stop_sending();
                while (sb.owed.size() != 0) @(posedge i_clk);
            end
            push_item(ikc_pkg::CMD_SAMPLE, COEF_IDX_W'($urandom), COEF_W'($urandom),
                      pick_sample());
        end
        stop_sending();
        phases_run++;
    endtask

    initial begin
        int unsigned ks, w, h, nc, nbytes;
        in_ch.valid = 1'b0;
        in_ch.cmd = ikc_pkg::CMD_SAMPLE;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        in_ch.sample = '0;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes, including loads past the store that must be dropped
        push_item(ikc_pkg::CMD_COEF, 8'd224, -18'sd131072, 8'd0);
        push_item(ikc_pkg::CMD_COEF, 8'd225, 18'sd131071, 8'd255);
        push_item(ikc_pkg::CMD_COEF, 8'd255, 18'sd131071, 8'd255);
        push_item(ikc_pkg::CMD_COEF, 8'd0, 18'sd131071, 8'd0);
        stop_sending();

        // Directed configurations: corner geometry and kernel sizes
        run_phase(3, 5, 4, 3, 120, 1'b0, 1'b0);      // two whole frames, wrap at frame end
        run_phase(4, 6, 5, 1, 30, 1'b1, 1'b0);       // even size acts as next odd
        run_phase(0, 4095, 0, 7, 150, 1'b1, 1'b0);   // all clamps: width, height, channels
        run_phase(7, 3, 20, 1, 30, 1'b0, 1'b0);      // window wider than image: silent
        run_phase(15, 16, 15, 1, 240, 1'b0, 1'b0);   // largest kernel just fits
        run_phase(1, 0, 4095, 0, 50, 1'b1, 1'b0);    // width and channels clamp up to 1

        // Random configurations, mostly whole frames of small images
        while (items_sent < 1300 || phases_run < 8) begin
            ks = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : 2 * $urandom_range(0, 2) + 1;
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 8);
            nc = $urandom_range(1, 4);
            nbytes = w * h * nc * $urandom_range(1, 3);
            if ($urandom_range(4) == 0) nbytes = $urandom_range(1, nbytes);
            if (nbytes > 150) nbytes = 150;
            steady = (phases_run == 6);
            run_phase(ks, w, h, nc, nbytes, $urandom_range(1), phases_run == 7);
        end
        steady = 1'b0;

        drain();
        $display("Covered %0d configurations and %0d input transfers.",
                 phases_run, items_sent);
        $display("Checked %0d results, %0d of them frame ends.",
                 sb.results_seen, sb.last_flags);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("ERROR: %0d mismatches, %0d results still owed",
                     sb.mismatches, sb.owed.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
